// ----- hw/rtl/i2da_pkg.sv -----
// ----------------------------------------------------------------------------
// i2da_pkg
// Shared types and constants of the integer to decimal ascii converter.
// ----------------------------------------------------------------------------
`default_nettype none

package i2da_pkg;

    // default field width limit
    localparam int C_MAX_WIDTH = 10;

    // digit store
    localparam int C_NUM_DIGITS = 5;
    localparam int C_W_DIG_IDX  = $clog2(C_NUM_DIGITS);
    localparam int C_W_DIG_CNT  = $clog2(C_NUM_DIGITS + 1);

    // divide by ten through a reciprocal, exact for values below 81920
    localparam logic [15:0] C_RADIX     = 16'd10;
    localparam logic [31:0] C_RECIP10   = 32'd52429;
    localparam int          C_RECIP_SHR = 19;

    // characters
    localparam logic [7:0] C_CH_ZERO  = 8'h30;
    localparam logic [7:0] C_CH_MINUS = 8'h2D;
    localparam logic [7:0] C_CH_SPACE = 8'h20;
    localparam logic [7:0] C_CH_NONE  = 8'h00;

    // modes
    localparam logic [1:0] MODE_SIGNED = 2'd0;
    localparam logic [1:0] MODE_ZPAD   = 2'd1;
    localparam logic [1:0] MODE_SPAD   = 2'd2;
    localparam logic [1:0] MODE_ALT    = 2'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] value;
        logic [3:0]  width;
    } t_req;

    typedef struct packed {
        logic [7:0] char_out;
        logic       last;
        logic       overflow;
    } t_res;

endpackage

`default_nettype wire

// ----- hw/rtl/i2da_div10.sv -----
// ----------------------------------------------------------------------------
// i2da_div10
// Shared digit unit: quotient and remainder of a 16-bit value by ten.
// ----------------------------------------------------------------------------
`default_nettype none

module i2da_div10 (
    input  wire logic [15:0] i_mag,
    output logic      [15:0] o_quot,
    output logic      [3:0]  o_rem
);
    import i2da_pkg::*;

    logic [31:0] w_prod;
    logic [15:0] w_quot;
    logic [15:0] w_back;

    // reciprocal multiply, then shift down
    assign w_prod = 32'(i_mag) * C_RECIP10;
    assign w_quot = 16'(w_prod >> C_RECIP_SHR);

    // remainder from quotient times ten
    assign w_back = 16'(w_quot * C_RADIX);
    assign o_quot = w_quot;
    assign o_rem  = 4'(i_mag - w_back);

endmodule

`default_nettype wire

// ----- hw/rtl/integer_to_decimal_ascii_top.sv -----
// ----------------------------------------------------------------------------
// integer_to_decimal_ascii_top
// Converts a 16-bit number to decimal ascii text, one character per cycle.
// ----------------------------------------------------------------------------
//  channel   | handshake         | payload
//  ----------+-------------------+------------------------------
//  request   | start / busy      | i_req  (mode, value, width)
//  result    | o_strobe          | o_res  (char_out, last, overflow)
//
//  a request runs digit steps through the shared divide-by-ten unit (1..5
//  digits), then a step to size the field, then the results (as many as the
//  field width or text length); an overflow result comes straight from the
//  sizing step
//  busy stays high from acceptance until the last result is registered
//  synchronous active-low reset clears the sequencer and the strobe
//  each result is shown for exactly one cycle; the receiver cannot stall
// ----------------------------------------------------------------------------
`default_nettype none

module integer_to_decimal_ascii_top #(
    parameter int MAX_WIDTH = i2da_pkg::C_MAX_WIDTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire i2da_pkg::t_req i_req,
    output logic               o_strobe,
    output i2da_pkg::t_res     o_res
);
    import i2da_pkg::*;

    localparam int W_FLD = $clog2(MAX_WIDTH + 1);
    localparam int W_CMP = (W_FLD > 4) ? W_FLD : 4;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CONV = 2'd1;
    localparam logic [1:0] S_PREP = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0]             r_state, n_state;
    logic [1:0]             r_mode,  n_mode;
    logic                   r_neg,   n_neg;
    logic [15:0]            r_mag,   n_mag;
    logic [3:0]             r_width, n_width;
    logic [3:0]             r_dig [0:C_NUM_DIGITS-1];
    logic [3:0]             n_dig [0:C_NUM_DIGITS-1];
    logic [C_W_DIG_CNT-1:0] r_nd,    n_nd;
    logic [W_FLD-1:0]       r_pad,   n_pad;
    logic                   r_sgn,   n_sgn;
    logic [C_W_DIG_IDX-1:0] r_di,    n_di;
    logic                   r_strobe, n_strobe;
    t_res                   r_res,   n_res;

    logic [15:0]            w_quot;
    logic [3:0]             w_rem;
    logic [1:0]             w_mode;
    logic                   w_neg;
    logic [W_FLD-1:0]       w_textlen;
    logic [W_CMP-1:0]       w_wsat;
    logic [W_FLD-1:0]       w_field;

    // shared digit unit
    i2da_div10 u_div10 (
        .i_mag  (r_mag),
        .o_quot (w_quot),
        .o_rem  (w_rem)
    );

    // request decode
    assign w_mode = (i_req.mode == MODE_ALT) ? MODE_SIGNED : i_req.mode;
    assign w_neg  = (w_mode != MODE_ZPAD) && i_req.value[15];

    // field sizing
    assign w_textlen = W_FLD'(r_nd) + W_FLD'(r_neg);
    assign w_wsat    = (W_CMP'(r_width) > W_CMP'(MAX_WIDTH)) ? W_CMP'(MAX_WIDTH)
                                                             : W_CMP'(r_width);
    assign w_field   = (r_mode == MODE_SIGNED) ? w_textlen : W_FLD'(w_wsat);

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_mode   = r_mode;
        n_neg    = r_neg;
        n_mag    = r_mag;
        n_width  = r_width;
        n_dig    = r_dig;
        n_nd     = r_nd;
        n_pad    = r_pad;
        n_sgn    = r_sgn;
        n_di     = r_di;
        n_strobe = 1'b0;
        n_res    = r_res;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_mode  = w_mode;
                    n_neg   = w_neg;
                    n_mag   = w_neg ? 16'(~i_req.value + 16'd1) : i_req.value;
                    n_width = i_req.width;
                    n_nd    = '0;
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                n_dig[r_nd[C_W_DIG_IDX-1:0]] = w_rem;
                n_nd  = r_nd + C_W_DIG_CNT'(1);
                n_mag = w_quot;
                if ((w_quot == 16'd0) || (r_nd == C_W_DIG_CNT'(C_NUM_DIGITS - 1))) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                if ((r_mode != MODE_SIGNED) && (w_textlen > w_field)) begin
                    n_strobe       = 1'b1;
                    n_res.char_out = C_CH_NONE;
                    n_res.last     = 1'b1;
                    n_res.overflow = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    n_pad   = w_field - w_textlen;
                    n_sgn   = r_neg;
                    n_di    = C_W_DIG_IDX'(r_nd - C_W_DIG_CNT'(1));
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                n_strobe       = 1'b1;
                n_res.overflow = 1'b0;
                n_res.last     = 1'b0;
                if (r_pad != '0) begin
                    n_res.char_out = (r_mode == MODE_ZPAD) ? C_CH_ZERO : C_CH_SPACE;
                    n_pad          = r_pad - W_FLD'(1);
                end else if (r_sgn) begin
                    n_res.char_out = C_CH_MINUS;
                    n_sgn          = 1'b0;
                end else begin
                    n_res.char_out = C_CH_ZERO + 8'(r_dig[r_di]);
                    if (r_di == '0) begin
                        n_res.last = 1'b1;
                        n_state    = S_IDLE;
                    end else begin
                        n_di = r_di - C_W_DIG_IDX'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_mode  <= n_mode;
        r_neg   <= n_neg;
        r_mag   <= n_mag;
        r_width <= n_width;
        r_dig   <= n_dig;
        r_nd    <= n_nd;
        r_pad   <= n_pad;
        r_sgn   <= n_sgn;
        r_di    <= n_di;
        r_res   <= n_res;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_res    = r_res;

endmodule

`default_nettype wire

// ----- hw/rtl/i2da_check.sv -----
// ----------------------------------------------------------------------------
// i2da_check
// Port-level checks of the converter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module i2da_check (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           start,
    input wire logic           busy,
    input wire i2da_pkg::t_res o_res,
    input wire logic           o_strobe
);
    import i2da_pkg::*;

    // an accepted request makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after request");

    // characters of one number come on consecutive cycles
    a_text_contig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_res.last) |=> o_strobe)
        else $error("gap inside text");

    // the block stays busy while a number is still being written
    a_busy_midtext: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_res.last) |-> busy)
        else $error("not busy in middle of text");

    // overflow is a single closing result with no character
    a_ovf_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_res.overflow) |-> (o_res.last && (o_res.char_out == C_CH_NONE)))
        else $error("malformed overflow result");

endmodule

bind integer_to_decimal_ascii_top i2da_check u_i2da_check (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_res    (o_res),
    .o_strobe (o_strobe)
);

`default_nettype wire
